[sv/gbs_pkg.sv]
// Package for the greedy box suppression core.
// Holds the beat structs, store entry type, FSM states and the overlap helper.
// No dependencies.
package gbs_pkg;

	localparam int MAX_KEPT   = 64;
	localparam int MAX_ITEMS  = 4096;
	localparam int RANK_W     = $clog2(MAX_KEPT);
	localparam int COUNT_W    = $clog2(MAX_KEPT + 1);
	localparam int INDEX_W    = 12;
	localparam int THR_W      = 9;
	localparam int AREA_W     = 30;
	localparam int UNION_W    = 31;
	localparam int PROD_W     = 40;

	localparam logic [THR_W-1:0]   THR_RESET = THR_W'(102);
	localparam logic [INDEX_W-1:0] ITEM_LAST = INDEX_W'(MAX_ITEMS - 1);
	localparam logic [COUNT_W-1:0] KEPT_FULL = COUNT_W'(MAX_KEPT);

	// Input beat
	typedef struct packed {
		logic               start_frame;
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic [14:0]        box_width;
		logic [14:0]        box_height;
	} gbs_in_t;

	// Result beat
	typedef struct packed {
		logic               keep;
		logic [INDEX_W-1:0] item_index;
		logic [RANK_W-1:0]  kept_rank;
		logic               overflow;
	} gbs_out_t;

	// Geometry of one box
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} kbox_t;

	// One kept-store entry
	typedef struct packed {
		kbox_t             box;
		logic [AREA_W-1:0] area;
	} entry_t;

	// Controls from the sequencer to the compare pipeline
	typedef struct packed {
		logic              rd_en;
		logic [RANK_W-1:0] rd_addr;
		logic              wr_en;
		logic [RANK_W-1:0] wr_addr;
	} pipe_ctrl_t;

	// Status from the compare pipeline back to the sequencer
	typedef struct packed {
		logic busy;
		logic hit;
	} pipe_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Length of the overlap of two 1-D intervals, zero if they do not overlap
	function automatic logic [14:0] overlap_len(
		input logic signed [15:0] a0,
		input logic [14:0]        al,
		input logic signed [15:0] b0,
		input logic [14:0]        bl
	);
		logic signed [16:0] a1;
		logic signed [16:0] b1;
		logic signed [16:0] lo;
		logic signed [16:0] hi;
		logic signed [17:0] d;
		a1 = 17'(a0) + $signed({2'b00, al});
		b1 = 17'(b0) + $signed({2'b00, bl});
		lo = (a0 > b0) ? 17'(a0) : 17'(b0);
		hi = (a1 < b1) ? a1 : b1;
		d  = 18'(hi) - 18'(lo);
		return (d > 18'sd0) ? d[14:0] : 15'd0;
	endfunction

endpackage

[sv/greedy_box_suppression_core.sv]
// Top level of the greedy box suppression core: command handshake,
// frame bookkeeping and scan sequencer. Depends on gbs_pkg and gbs_iou_pipe.

// Boxes enter sorted by descending score, one per command (start high while
// busy is low). Each box is tested against every box kept so far in the frame,
// one stored box per cycle from the kept-box memory, through a four-stage
// compare pipeline. From acceptance to its result an item makes one read per
// stored box, waits for the pipeline to drain, then writes the box back and
// presents the result. With an empty kept list nothing enters the pipeline.
// The result is shown for exactly one cycle with done high and must be taken
// then; busy stays high until that cycle is over.
// The threshold may be written only while busy is low.
module greedy_box_suppression_core import gbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gbs_in_t          cmd,
	output logic             done,
	output gbs_out_t         result,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata
);

	state_t             state_q;
	state_t             state_d;
	logic [THR_W-1:0]   thr_q;
	logic [COUNT_W-1:0] count_q;
	logic [INDEX_W-1:0] item_q;
	logic [INDEX_W-1:0] idx_q;
	logic [COUNT_W-1:0] rd_idx_q;
	logic               suppress_q;
	kbox_t              box_q;
	logic [AREA_W-1:0]  area_q;
	logic               accept;
	logic               full;
	logic               store_it;
	logic [INDEX_W-1:0] item_cur;
	pipe_ctrl_t         ctrl;
	pipe_stat_t         stat;

	assign accept   = start && (state_q == ST_IDLE);
	assign full     = (count_q == KEPT_FULL);
	assign store_it = !suppress_q && !full;
	assign item_cur = cmd.start_frame ? '0 : item_q;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and pipeline controls
	always_comb begin
		state_d      = state_q;
		busy         = 1'b1;
		done         = 1'b0;
		ctrl.rd_en   = 1'b0;
		ctrl.rd_addr = rd_idx_q[RANK_W-1:0];
		ctrl.wr_en   = 1'b0;
		ctrl.wr_addr = count_q[RANK_W-1:0];
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_idx_q < count_q) begin
					ctrl.rd_en = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				done       = 1'b1;
				ctrl.wr_en = store_it;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Frame bookkeeping: kept count, item counter, scan index, suppress flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			item_q     <= '0;
			rd_idx_q   <= '0;
			suppress_q <= 1'b0;
		end else begin
			if (accept) begin
				if (cmd.start_frame) begin
					count_q <= '0;
				end
				item_q     <= (item_cur < ITEM_LAST) ? item_cur + 1'b1 : item_cur;
				rd_idx_q   <= '0;
				suppress_q <= 1'b0;
			end else begin
				if (ctrl.rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (stat.hit) begin
					suppress_q <= 1'b1;
				end
				if (ctrl.wr_en) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Hold the candidate box, its index and its area for the whole item
	always_ff @(posedge clk) begin
		if (accept) begin
			box_q <= '{x: cmd.box_x, y: cmd.box_y, w: cmd.box_width, h: cmd.box_height};
			idx_q <= item_cur;
		end
		area_q <= {15'd0, box_q.w} * {15'd0, box_q.h};
	end

	gbs_iou_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cand      (box_q),
		.cand_area (area_q),
		.thr       (thr_q),
		.stat      (stat)
	);

	// Result beat
	assign result.keep       = !suppress_q;
	assign result.item_index = idx_q;
	assign result.kept_rank  = store_it ? count_q[RANK_W-1:0] : '0;
	assign result.overflow   = !suppress_q && full;

	// The kept count never exceeds the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= KEPT_FULL)
		else $error("kept count beyond store depth");

	// A result strobe is followed by an idle cycle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	// Compare hits only arrive while an item is being scanned
	a_hit_scan: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("compare hit outside a scan");

	// No store read is issued beyond the kept count
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_en |-> (rd_idx_q < count_q))
		else $error("read beyond kept entries");

endmodule

[sv/gbs_iou_pipe.sv]
// Kept-box store and the IoU compare pipeline.
// One stored box is read and tested per cycle; kept boxes are written back.
// Depends on gbs_pkg.
module gbs_iou_pipe import gbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  pipe_ctrl_t          ctrl,
	input  kbox_t               cand,
	input  logic [AREA_W-1:0]   cand_area,
	input  logic [THR_W-1:0]    thr,
	output pipe_stat_t          stat
);

	entry_t store [MAX_KEPT];

	entry_t             rdata_s1;
	logic               v_s1;
	logic [14:0]        iw_s2;
	logic [14:0]        ih_s2;
	logic [AREA_W-1:0]  karea_s2;
	logic               v_s2;
	logic [AREA_W-1:0]  inter_s3;
	logic [AREA_W-1:0]  karea_s3;
	logic               v_s3;
	logic [AREA_W-1:0]  inter_s4;
	logic [UNION_W-1:0] uni_s4;
	logic               v_s4;
	logic [PROD_W-1:0]  lhs;
	logic [PROD_W-1:0]  rhs;

	// Write a kept box, read one stored entry with registered data
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			store[ctrl.wr_addr] <= '{box: cand, area: cand_area};
		end
		rdata_s1 <= store[ctrl.rd_addr];
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctrl.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Overlap extents, intersection, union
	always_ff @(posedge clk) begin
		iw_s2    <= overlap_len(cand.x, cand.w, rdata_s1.box.x, rdata_s1.box.w);
		ih_s2    <= overlap_len(cand.y, cand.h, rdata_s1.box.y, rdata_s1.box.h);
		karea_s2 <= rdata_s1.area;
		inter_s3 <= {15'd0, iw_s2} * {15'd0, ih_s2};
		karea_s3 <= karea_s2;
		inter_s4 <= inter_s3;
		uni_s4   <= UNION_W'(cand_area) + UNION_W'(karea_s3) - UNION_W'(inter_s3);
	end

	// Threshold test: inter*256 > thr*union
	assign lhs = PROD_W'({inter_s4, 8'd0});
	assign rhs = PROD_W'(thr) * PROD_W'(uni_s4);

	assign stat.hit  = v_s4 && (lhs > rhs);
	assign stat.busy = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

[sim/testbench.sv]
// Self-checking testbench for greedy_box_suppression_core.
// Drives boxes through the start/busy command port, predicts keep/rank/overflow
// per box and checks every result beat. Depends on gbs_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
	import gbs_pkg::*;

	localparam int CYCLE_LIMIT = 1_200_000;
	localparam int RANDOM_BOXES = 1000;
	localparam int PRINT_CAP = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	gbs_in_t             cmd = '0;
	logic                cfg_we = 1'b0;
	logic [THR_W-1:0]    cfg_wdata = '0;
	logic                busy;
	logic                done;
	gbs_out_t            result;

	// Boxes waiting for the driver, and result beats owed by the core
	gbs_in_t             box_backlog[$];
	gbs_out_t            expected_results[$];

	// Shadow copy of the suppression state
	logic signed [15:0]  kept_x[MAX_KEPT];
	logic signed [15:0]  kept_y[MAX_KEPT];
	logic [14:0]         kept_w[MAX_KEPT];
	logic [14:0]         kept_h[MAX_KEPT];
	logic [AREA_W-1:0]   kept_area[MAX_KEPT];
	int unsigned         kept_total = 0;
	logic [INDEX_W-1:0]  next_index = '0;
	logic [THR_W-1:0]    overlap_thr = THR_RESET;

	// Bookkeeping
	int                  mismatches = 0;
	int                  results_seen = 0;
	int                  boxes_accepted = 0;
	int                  frames_seen = 0;
	int                  kept_seen = 0;
	int                  dropped_seen = 0;
	int                  overflow_seen = 0;
	int                  saturated_seen = 0;
	int                  thr_writes = 0;
	int                  queued_total = 0;
	int                  gap_left = 0;
	int                  calm_left = 0;
	longint              cycle_count = 0;

	greedy_box_suppression_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Length of the overlap of two 1-D spans, zero when they only touch or miss
	function automatic longint span_overlap(input logic signed [15:0] p0,
			input logic [14:0] plen, input logic signed [15:0] q0,
			input logic [14:0] qlen);
		longint p1;
		longint q1;
		longint lo;
		longint hi;
		p1 = longint'(p0) + longint'(plen);
		q1 = longint'(q0) + longint'(qlen);
		lo = (longint'(p0) > longint'(q0)) ? longint'(p0) : longint'(q0);
		hi = (p1 < q1) ? p1 : q1;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	// Run one box through greedy suppression and return the beat it must produce
	function automatic gbs_out_t judge_box(input gbs_in_t b);
		gbs_out_t r;
		longint ov_w;
		longint ov_h;
		longint inter;
		longint uni;
		longint area;
		bit survive;
		int i;
		survive = 1'b1;
		if (b.start_frame) begin
			kept_total = 0;
			next_index = '0;
		end
		area = longint'(b.box_width) * longint'(b.box_height);
		for (i = 0; i < int'(kept_total); i++) begin
			ov_w = span_overlap(b.box_x, b.box_width, kept_x[i], kept_w[i]);
			ov_h = span_overlap(b.box_y, b.box_height, kept_y[i], kept_h[i]);
			inter = ov_w * ov_h;
			uni = area + longint'(kept_area[i]) - inter;
			if (inter * 256 > longint'(overlap_thr) * uni)
				survive = 1'b0;
		end
		r = '0;
		r.keep = survive;
		if (survive) begin
			if (kept_total < MAX_KEPT) begin
				kept_x[kept_total] = b.box_x;
				kept_y[kept_total] = b.box_y;
				kept_w[kept_total] = b.box_width;
				kept_h[kept_total] = b.box_height;
				kept_area[kept_total] = AREA_W'(area);
				r.kept_rank = RANK_W'(kept_total);
				kept_total++;
			end else begin
				r.overflow = 1'b1;
			end
		end
		r.item_index = next_index;
		if (next_index != ITEM_LAST)
			next_index++;
		return r;
	endfunction

	// Idle cycles after a beat: mostly none or short, a few long, some calm runs
	function automatic int next_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("ERROR %0t: result %0d %s got %0d want %0d", $time, results_seen,
				what, got, want);
	endtask

	task automatic add_box(input bit sf, input int x, input int y, input int w,
			input int h);
		gbs_in_t b;
		b.start_frame = sf;
		b.box_x = 16'(x);
		b.box_y = 16'(y);
		b.box_width = 15'(w);
		b.box_height = 15'(h);
		box_backlog.insert(box_backlog.size(), b);
		queued_total++;
	endtask

	// Fully random box, with field extremes forced now and then
	task automatic add_random_box(input bit allow_start);
		logic [63:0] raw;
		gbs_in_t b;
		raw = {$urandom, $urandom};
		b = raw[$bits(gbs_in_t)-1:0];
		if (!allow_start)
			b.start_frame = 1'b0;
		case ($urandom_range(0, 9))
			0: b.box_width = '0;
			1: b.box_height = '1;
			2: b.box_x = 16'sh8000;
			3: b.box_y = 16'sh7fff;
			4: b.box_width = '1;
			default: ;
		endcase
		box_backlog.insert(box_backlog.size(), b);
		queued_total++;
	endtask

	// Frame of boxes jittered around a few centers so overlaps sit near threshold
	task automatic queue_cluster_frame(input int n);
		int cx[4];
		int cy[4];
		int cw[4];
		int ch[4];
		int k;
		int c;
		int i;
		int w;
		int h;
		bit sf;
		k = $urandom_range(1, 4);
		for (i = 0; i < k; i++) begin
			cx[i] = $urandom_range(0, 56000) - 28000;
			cy[i] = $urandom_range(0, 56000) - 28000;
			cw[i] = $urandom_range(1, 2000);
			ch[i] = $urandom_range(1, 2000);
		end
		for (i = 0; i < n; i++) begin
			// Drop the frame flag now and then to continue the previous frame
			sf = (i == 0) && ($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 11) == 0) begin
				add_random_box(sf);
			end else begin
				c = $urandom_range(0, k - 1);
				w = cw[c] + $urandom_range(0, cw[c] / 2) - cw[c] / 4;
				h = ch[c] + $urandom_range(0, ch[c] / 2) - ch[c] / 4;
				add_box(sf, cx[c] + $urandom_range(0, cw[c] / 2) - cw[c] / 4,
					cy[c] + $urandom_range(0, ch[c] / 2) - ch[c] / 4,
					(w < 0) ? 0 : w, (h < 0) ? 0 : h);
			end
		end
	endtask

	// Frame of disjoint grid tiles with a few repeats, often enough to fill the store
	task automatic queue_grid_frame(input int n);
		int ox;
		int oy;
		int s;
		int i;
		int tile;
		ox = $urandom_range(0, 20000) - 20000;
		oy = $urandom_range(0, 20000) - 20000;
		s = $urandom_range(16, 200);
		for (i = 0; i < n; i++) begin
			tile = ($urandom_range(0, 9) == 0) ? $urandom_range(0, i) : i;
			add_box(i == 0, ox + (tile % 10) * s * 2, oy + (tile / 10) * s * 2, s, s);
		end
	endtask

	// Wait until the core is idle and no result is owed
	task automatic wait_idle();
		do
			@(negedge clk);
		while (box_backlog.size() != 0 || expected_results.size() != 0 || start || busy);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		overlap_thr <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_writes++;
		@(negedge clk);
	endtask

	// Driver: present the next box, hold it while busy, count off idle gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), judge_box(cmd));
				boxes_accepted++;
				if (cmd.start_frame)
					frames_seen++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (box_backlog.size() > 0) begin
					cmd <= box_backlog.pop_front();
					start <= 1'b1;
					gap_left = next_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: take each result beat and compare it with the oldest prediction
	always @(posedge clk) begin
		gbs_out_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("arrived with no box pending, index",
					32'(result.item_index), 0);
			end else begin
				want = expected_results.pop_front();
				if (result.keep !== want.keep)
					report_mismatch("keep", 32'(result.keep), 32'(want.keep));
				if (result.item_index !== want.item_index)
					report_mismatch("item_index", 32'(result.item_index),
						32'(want.item_index));
				if (result.kept_rank !== want.kept_rank)
					report_mismatch("kept_rank", 32'(result.kept_rank),
						32'(want.kept_rank));
				if (result.overflow !== want.overflow)
					report_mismatch("overflow", 32'(result.overflow), 32'(want.overflow));
				if (want.overflow)
					overflow_seen++;
				else if (want.keep)
					kept_seen++;
				else
					dropped_seen++;
				if (want.item_index == ITEM_LAST)
					saturated_seen++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL greedy_box_suppression_core");
			$finish;
		end
	end

	initial begin
		int mark;
		int phase_end;
		int i;
		logic [THR_W-1:0] thr;
		gbs_in_t dup;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed at the reset threshold: no frame flag, empties, edges, extremes
		add_box(0, 0, 0, 160, 160);
		add_box(0, 0, 0, 160, 160);
		add_box(0, 40, 40, 0, 160);
		add_box(0, 40, 40, 160, 0);
		add_box(0, 160, 0, 160, 160);
		add_box(0, -32768, -32768, 32767, 32767);
		add_box(0, 32767, 32767, 32767, 32767);
		add_box(0, 0, 0, 32767, 32767);
		// Overlap one step either side of the 102/256 boundary
		add_box(1, 1000, 1000, 100, 100);
		add_box(0, 1043, 1000, 100, 100);
		add_box(0, 1044, 1000, 100, 100);
		add_box(0, -32768, 32767, 16, 16);

		// Zero threshold: any overlap suppresses, empty boxes still survive
		write_threshold('0);
		add_box(1, 0, 0, 100, 100);
		add_box(0, 99, 99, 100, 100);
		add_box(0, 0, 0, 0, 0);
		add_box(0, 0, 0, 0, 0);
		add_box(0, 100, 0, 100, 100);

		// Full threshold: identical boxes all survive until the store fills
		write_threshold(THR_W'(256));
		add_random_box(0);
		dup = box_backlog[box_backlog.size() - 1];
		dup.start_frame = 1'b1;
		box_backlog[box_backlog.size() - 1] = dup;
		dup.start_frame = 1'b0;
		for (i = 0; i < MAX_KEPT + 1; i++) begin
			box_backlog.insert(box_backlog.size(), dup);
			queued_total++;
		end
		add_random_box(0);

		// Threshold beyond one, then random phases at varied settings
		write_threshold('1);
		queue_cluster_frame(12);
		mark = queued_total;
		while (queued_total - mark < RANDOM_BOXES) begin
			phase_end = queued_total + $urandom_range(120, 250);
			if (phase_end > mark + RANDOM_BOXES)
				phase_end = mark + RANDOM_BOXES;
			while (queued_total < phase_end) begin
				case ($urandom_range(0, 19))
					0, 1: queue_grid_frame($urandom_range(60, 75));
					2, 3: begin
						repeat ($urandom_range(1, 6)) add_random_box(1);
					end
					default: queue_cluster_frame($urandom_range(2, 30));
				endcase
			end
			case ($urandom_range(0, 6))
				0: thr = '0;
				1: thr = THR_W'(256);
				2: thr = THR_W'(1);
				3: thr = THR_W'(255);
				4: thr = THR_RESET;
				default: thr = THR_W'($urandom_range(0, 256));
			endcase
			write_threshold(thr);
		end

		// Restart a frame at the reset threshold
		write_threshold(THR_RESET);
		add_box(1, 2000, 2000, 320, 320);
		add_box(0, 2010, 2000, 320, 320);

		wait_idle();
		repeat (80) @(posedge clk);

		$display("Ran %0d boxes in %0d flagged frames over %0d threshold writes.",
			boxes_accepted, frames_seen, thr_writes);
		$display("Results: %0d kept, %0d suppressed, %0d overflowed, %0d at the index cap.",
			kept_seen, dropped_seen, overflow_seen, saturated_seen);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS greedy_box_suppression_core");
		else
			$display("FAIL greedy_box_suppression_core");
		$finish;
	end

endmodule
